@@ sv/sks_pkg.sv @@
// Shared types and constants for the sorted key set.
`default_nettype none
package sks_pkg;

   localparam int KEY_W         = 16;
   localparam int CMD_W         = 2;
   localparam int ENTRY_COUNT_W = 9;

   typedef enum logic [CMD_W-1:0] {
      CMD_MEMBER = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic             insert_en;
      logic             delete_en;
      logic [KEY_W-1:0] key;
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ sv/sorted_key_set_core.sv @@
// Sorted key set: chain of key cells with a sequencer and an OR tree for presence.
//
// Holds up to CAPACITY distinct 16-bit keys in ascending order, one key per
// cell. Each item (member, insert or delete) is looked up and then applied;
// the lookup goes through the registered eight-way OR tree of LEVELS =
// ceil(log2(CAPACITY)/3) levels that gathers the per-cell match flags into
// one presence bit before the whole chain shifts at once. A new item is
// taken once the previous one has been applied, so no new item is accepted
// while one is in search or apply; the result waits in its own register
// until taken and a result still waiting holds off the apply of the next
// item.
`default_nettype none
module sorted_key_set_core
   import sks_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [CMD_W-1:0]         req_command,
   input  wire logic [KEY_W-1:0]         req_key,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_success,
   output logic                          rsp_rejected_full,
   output logic [ENTRY_COUNT_W-1:0]      rsp_entry_count
);

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int LEVELS = ($clog2(CAPACITY) + 2) / 3;
   localparam int WAIT_W = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;

   state_type           state_ff, state_in;
   logic [WAIT_W-1:0]   wait_ff, wait_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [KEY_W-1:0]    key_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_success_ff, rsp_success_in;
   logic                rsp_full_ff, rsp_full_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                rsp_free;
   logic                apply_fire;
   logic                present;
   logic                is_full;
   logic                do_insert;
   logic                do_delete;
   cell_ctrl_type       ctrl;

   logic                     lt_vec    [CAPACITY];
   logic [KEY_W-1:0]         entry_vec [CAPACITY];
   logic [CAPACITY-1:0]      eq_vec;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign is_full   = (count_ff == CW'(CAPACITY));
   assign do_insert = (cmd_ff == CMD_INSERT) && !present && !is_full;
   assign do_delete = (cmd_ff == CMD_DELETE) && present;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (wait_ff == WAIT_W'(LEVELS)) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      apply_fire = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready  = 1'b1;
         ST_SEARCH: ;
         ST_APPLY:  apply_fire = rsp_free;
         default:   ;
      endcase
   end

   always_comb begin
      wait_in = '0;
      if (state_ff == ST_SEARCH) wait_in = wait_ff + 1'b1;
   end

   assign ctrl.insert_en = apply_fire && do_insert;
   assign ctrl.delete_en = apply_fire && do_delete;
   assign ctrl.key       = key_ff;

   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_success_in = rsp_success_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_count_in   = rsp_count_ff;
      if (apply_fire) begin
         if (do_insert) count_in = count_ff + 1'b1;
         if (do_delete) count_in = count_ff - 1'b1;
         rsp_valid_in   = 1'b1;
         rsp_success_in = ((cmd_ff == CMD_MEMBER) && present) || do_insert || do_delete;
         rsp_full_in    = (cmd_ff == CMD_INSERT) && !present && is_full;
         rsp_count_in   = ENTRY_COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_command;
         key_ff <= req_key;
      end
      rsp_success_ff <= rsp_success_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_count_ff   <= rsp_count_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic             left_lt;
      logic [KEY_W-1:0] left_key;
      logic [KEY_W-1:0] right_key;

      if (i == 0) begin : g_first
         assign left_lt  = 1'b1;
         assign left_key = key_ff;
      end else begin : g_mid
         assign left_lt  = lt_vec[i-1];
         assign left_key = entry_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = entry_vec[i];
      end else begin : g_inner
         assign right_key = entry_vec[i+1];
      end

      sks_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .left_lt   (left_lt),
         .left_key  (left_key),
         .right_key (right_key),
         .lt        (lt_vec[i]),
         .eq        (eq_vec[i]),
         .entry     (entry_vec[i])
      );
   end

   sks_or_tree #(
      .WIDTH (CAPACITY)
   ) u_or_tree (
      .clock   (clock),
      .bits_in (eq_vec),
      .any_out (present)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_success       = rsp_success_ff;
   assign rsp_rejected_full = rsp_full_ff;
   assign rsp_entry_count   = rsp_count_ff;

`ifndef SYNTH
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_count_moves_on_apply: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(state_ff == ST_APPLY))
      else $error("entry count changed outside apply");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_APPLY))
      else $error("result raised outside apply");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_success_ff && rsp_full_ff))
      else $error("success and full refusal both set");
`endif

endmodule
`default_nettype wire

@@ sv/sks_cell.sv @@
// One slot of the sorted chain: holds a key, compares it, shifts to a neighbor.
`default_nettype none
module sks_cell
   import sks_pkg::*;
#(
   parameter int IDX = 0,
   parameter int CW  = 9
) (
   input  wire logic                clock,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [CW-1:0]       count,
   input  wire logic                left_lt,
   input  wire logic [KEY_W-1:0]    left_key,
   input  wire logic [KEY_W-1:0]    right_key,
   output logic                     lt,
   output logic                     eq,
   output logic [KEY_W-1:0]         entry
);

   logic [KEY_W-1:0] entry_ff;
   logic [KEY_W-1:0] entry_in;
   logic             occupied;

   assign occupied = (count > CW'(IDX));
   assign lt       = occupied && (entry_ff < ctrl.key);
   assign eq       = occupied && (entry_ff == ctrl.key);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en && !lt) begin
         entry_in = left_lt ? ctrl.key : left_key;
      end else if (ctrl.delete_en && !lt) begin
         entry_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

@@ sv/sks_or_tree.sv @@
// Registered OR reduction tree, fan-in eight per level.
`default_nettype none
module sks_or_tree
   import sks_pkg::*;
#(
   parameter int WIDTH = 256
) (
   input  wire logic             clock,
   input  wire logic [WIDTH-1:0] bits_in,
   output logic                  any_out
);

   localparam int LEVELS = ($clog2(WIDTH) + 2) / 3;
   localparam int PAD    = 1 << (3 * LEVELS);

   logic [LEVELS:0][PAD-1:0] tree_ff;

   always_ff @(posedge clock) begin
      tree_ff[0] <= PAD'(bits_in);
      for (int l = 1; l <= LEVELS; l++) begin
         for (int n = 0; n < PAD; n++) begin
            if (n < PAD / 8) begin
               tree_ff[l][n] <= |tree_ff[l-1][n*8 +: 8];
            end else begin
               tree_ff[l][n] <= 1'b0;
            end
         end
      end
   end

   assign any_out = tree_ff[LEVELS][0];

endmodule
`default_nettype wire

@@ test/sks_set_checker.sv @@
`timescale 1ns / 100ps
// Checker for the sorted key set: predicts each response from the accepted requests and compares.
module sks_set_checker
   import sks_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [CMD_W-1:0]         req_command,
   input  wire logic [KEY_W-1:0]         req_key,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic                     rsp_success,
   input  wire logic                     rsp_rejected_full,
   input  wire logic [ENTRY_COUNT_W-1:0] rsp_entry_count,
   output int                            fail_count,
   output int                            pending_count
);

   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic                     success;
      logic                     rejected_full;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } set_reply_type;

   logic [KEY_W-1:0] held_keys [CAPACITY];
   int               held_total = 0;
   set_reply_type    predicted_replies [$];
   int               mismatches = 0;

   function automatic set_reply_type apply_set_op(input logic [CMD_W-1:0] command,
                                                  input logic [KEY_W-1:0] key);
      int            pos;
      logic          present;
      set_reply_type reply;
      pos = 0;
      while (pos < held_total && held_keys[pos] < key)
         pos++;
      present = (pos < held_total) && (held_keys[pos] == key);
      reply = '0;
      case (command)
         CMD_MEMBER: begin
            reply.success = present;
         end
         CMD_INSERT: begin
            if (!present) begin
               if (held_total >= CAPACITY) begin
                  reply.rejected_full = 1'b1;
               end else begin
                  for (int i = held_total; i > pos; i--)
                     held_keys[i] = held_keys[i-1];
                  held_keys[pos] = key;
                  held_total++;
                  reply.success = 1'b1;
               end
            end
         end
         CMD_DELETE: begin
            if (present) begin
               for (int i = pos; i < held_total - 1; i++)
                  held_keys[i] = held_keys[i+1];
               held_total--;
               reply.success = 1'b1;
            end
         end
         default: begin
         end
      endcase
      reply.entry_count = ENTRY_COUNT_W'(held_total);
      return reply;
   endfunction

   always @(posedge clock) begin
      set_reply_type want;
      if (reset) begin
         held_total = 0;
         predicted_replies.delete();
         mismatches = 0;
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: response with no request waiting: %s %0b full %0b count %0d",
                           $realtime, "success", rsp_success, rsp_rejected_full,
                           rsp_entry_count);
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_success !== want.success || rsp_rejected_full !== want.rejected_full ||
                   rsp_entry_count !== want.entry_count) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("%0t: mismatch: expected success %0b full %0b count %0d,%s",
                              $realtime, want.success, want.rejected_full, want.entry_count,
                              " got");
                  if (mismatches <= REPORT_MAX)
                     $display("   %0b %0b %0d", rsp_success, rsp_rejected_full,
                              rsp_entry_count);
               end
            end
         end
         if (req_valid && req_ready)
            predicted_replies.push_back(apply_set_op(req_command, req_key));
         fail_count <= mismatches;
         pending_count <= predicted_replies.size();
      end
   end

endmodule

@@ test/tb_sorted_key_set_core.sv @@
`timescale 1ns / 100ps
// Testbench top for the sorted key set core: stimulus, receiver backpressure and verdict.
module tb_sorted_key_set_core
   import sks_pkg::*;
();

   localparam int              CAPACITY    = 256;
   localparam int              LIMIT       = 200000;
   localparam int              HOLD_CYCLES = 300;
   localparam int              IDLE_PCT    = 32;
   localparam int              POOL_SIZE   = 280;
   localparam int              TAIL_CYCLES = 12;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic [CMD_W-1:0]         req_command  = CMD_MEMBER;
   logic [KEY_W-1:0]         req_key      = '0;
   logic                     rsp_ready    = 1'b0;
   logic                     req_ready;
   logic                     rsp_valid;
   logic                     rsp_success;
   logic                     rsp_rejected_full;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count;

   int                       fail_count;
   int                       pending_count;
   logic                     quiet_mode   = 1'b0;
   logic                     hold_trigger = 1'b0;
   logic                     hold_seen    = 1'b0;
   int                       hold_left    = 0;
   int                       cycle_count  = 0;
   logic [KEY_W-1:0]         key_pool [POOL_SIZE];
   int                       pool_idx     = 0;

   sorted_key_set_core #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_success(rsp_success),
      .rsp_rejected_full(rsp_rejected_full),
      .rsp_entry_count(rsp_entry_count)
   );

   sks_set_checker #(
      .CAPACITY(CAPACITY)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_success(rsp_success),
      .rsp_rejected_full(rsp_rejected_full),
      .rsp_entry_count(rsp_entry_count),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   task automatic send_item(input logic [CMD_W-1:0] command, input logic [KEY_W-1:0] key);
      if (!quiet_mode) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_command <= command;
      req_key <= key;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 95)
         return KEY_W'($urandom);
      else if (r < 98)
         return '1;
      else
         return '0;
   endfunction

   function automatic logic [CMD_W-1:0] pick_command(input int insert_pct, input int delete_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < insert_pct)
         return CMD_INSERT;
      else if (r < insert_pct + delete_pct)
         return CMD_DELETE;
      else if (r >= 96)
         return CMD_UNUSED;
      else
         return CMD_MEMBER;
   endfunction

   // receiver: random backpressure, full speed in quiet mode, long hold on trigger
   initial begin
      forever begin
         @(posedge clock);
         if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (quiet_mode) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_sorted_key_set_core: errors");
      $finish;
   end

   initial begin
      int r;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = KEY_W'($urandom);
      key_pool[0] = '0;
      key_pool[1] = '1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_MEMBER, 16'h0000);
      send_item(CMD_DELETE, 16'h0000);
      send_item(CMD_INSERT, 16'h0000);
      send_item(CMD_INSERT, 16'h0000);
      send_item(CMD_INSERT, 16'hFFFF);
      send_item(CMD_MEMBER, 16'hFFFF);
      send_item(CMD_MEMBER, 16'h8000);
      send_item(CMD_INSERT, 16'h8000);
      send_item(CMD_INSERT, 16'h7FFF);
      send_item(CMD_INSERT, 16'h0001);
      send_item(CMD_MEMBER, 16'h7FFF);
      send_item(CMD_DELETE, 16'h8000);
      send_item(CMD_DELETE, 16'h8000);
      send_item(CMD_UNUSED, 16'hFFFF);
      send_item(CMD_UNUSED, 16'h0000);
      send_item(CMD_DELETE, 16'h0000);
      send_item(CMD_INSERT, 16'hFFFE);
      send_item(CMD_DELETE, 16'hFFFF);
      send_item(CMD_MEMBER, 16'h0001);
      send_item(CMD_DELETE, 16'h0001);
      wait_drained();

      // fill past capacity, with the receiver holding off at the start
      hold_trigger <= ~hold_trigger;
      pool_idx = 0;
      for (int n = 0; n < 340; n++) begin
         r = $urandom_range(0, 99);
         if (r < 85) begin
            send_item(CMD_INSERT, key_pool[pool_idx]);
            pool_idx = (pool_idx + 1) % POOL_SIZE;
         end else if (r < 95) begin
            send_item(CMD_MEMBER, pick_key());
         end else if (r < 98) begin
            send_item(CMD_INSERT, pick_key());
         end else begin
            send_item(CMD_UNUSED, pick_key());
         end
      end
      wait_drained();

      quiet_mode <= 1'b1;
      for (int n = 0; n < 130; n++)
         send_item(pick_command(35, 35), pick_key());
      wait_drained();
      quiet_mode <= 1'b0;

      // delete the pool keys in order, mixed with other commands
      pool_idx = 0;
      for (int n = 0; n < 260; n++) begin
         if ($urandom_range(0, 99) < 90) begin
            send_item(CMD_DELETE, key_pool[pool_idx]);
            pool_idx = (pool_idx + 1) % POOL_SIZE;
         end else begin
            send_item(pick_command(10, 30), pick_key());
         end
      end
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_sorted_key_set_core: clean");
      else
         $display("tb_sorted_key_set_core: errors");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/sks_pkg.sv
sv/sks_cell.sv
sv/sks_or_tree.sv
sv/sorted_key_set_core.sv
test/sks_set_checker.sv
test/tb_sorted_key_set_core.sv
